/* src/dwpd_pkg.sv */
// ----------------------------------------------------------------------------
// dwpd_pkg - depth window presence detector shared definitions
// Image geometry, field widths, register indexes, queue item and window masks.
// ----------------------------------------------------------------------------
package dwpd_pkg;

    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;
    localparam int MAX_WINDOW   = 4;

    localparam int LINES    = MAX_WINDOW - 1;
    localparam int WIN_BITS = MAX_WINDOW * MAX_WINDOW;
    localparam int COL_W    = $clog2(IMAGE_WIDTH);
    localparam int ROW_W    = $clog2(IMAGE_HEIGHT);
    localparam int K_W      = $clog2(MAX_WINDOW + 1);
    localparam int PC_W     = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W    = $clog2(WIN_BITS + 1);

    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 16;
    localparam int WS_W      = 3;
    localparam int SLACK_W   = 5;
    localparam int BAND_W    = 10;
    localparam int LOC_W     = 11;
    localparam int MAXCNT_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DATA_W = 32;

    localparam int SCALE_NUM = 13;
    localparam int SCALE_DEN = 10;
    localparam int MULT_W    = DEPTH_W + 4;
    localparam int LOC_OFFSET = 2;

    localparam int JW0 = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int JW  = ((JW0 > BAND_W) ? JW0 : BAND_W) + 1;

    localparam int TW0 = (CNT_W > SLACK_W) ? CNT_W : SLACK_W;
    localparam int TW  = ((TW0 + 1) > (2 * K_W)) ? (TW0 + 1) : (2 * K_W);

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [DEPTH_W-1:0] RST_DEPTH_TH = 16'd2366;
    localparam logic [DEPTH_W-1:0] RST_PRES_TH  = 16'd410;
    localparam logic [WS_W-1:0]    RST_WS       = 3'd3;
    localparam logic [SLACK_W-1:0] RST_SLACK    = 5'd1;
    localparam logic [BAND_W-1:0]  RST_ROW_FIRST = 10'd0;
    localparam logic [BAND_W-1:0]  RST_ROW_LAST  = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_TH  = 3'd0,
        CFG_PRES_TH   = 3'd1,
        CFG_WIN_SIZE  = 3'd2,
        CFG_SLACK     = 3'd3,
        CFG_ROW_FIRST = 3'd4,
        CFG_ROW_LAST  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_th;
        logic [DEPTH_W-1:0] pres_th;
        logic [K_W-1:0]     k;
        logic [SLACK_W-1:0] slack;
        logic [BAND_W-1:0]  row_first;
        logic [BAND_W-1:0]  row_last;
    } t_cfg;

    typedef struct packed {
        logic [MAX_WINDOW-1:0] vert;
        logic                  judge;
        logic [LOC_W-1:0]      loc_x;
        logic [LOC_W-1:0]      loc_y;
        logic                  eof;
    } t_item;

    typedef struct packed {
        logic full;
        logic almost_full;
    } t_fifo_status;

    function automatic logic [K_W-1:0] clamp_k(input logic [WS_W-1:0] ws);
        if (ws == '0) begin
            return K_W'(1);
        end
        if (int'(ws) > MAX_WINDOW) begin
            return K_W'(MAX_WINDOW);
        end
        return K_W'(ws);
    endfunction

    function automatic logic [WIN_BITS-1:0] win_mask(input logic [K_W-1:0] k);
        logic [WIN_BITS-1:0] m;
        m = '0;
        for (int a = 0; a < MAX_WINDOW; a++) begin
            for (int b = 0; b < MAX_WINDOW; b++) begin
                m[a * MAX_WINDOW + b] = (a < int'(k)) && (b < int'(k));
            end
        end
        return m;
    endfunction

    function automatic logic [WIN_BITS-1:0] anchor_mask(input logic [K_W-1:0] k);
        logic [WIN_BITS-1:0] m;
        m = '0;
        for (int a = 0; a < MAX_WINDOW; a++) begin
            m[a * MAX_WINDOW + a] = (a == int'(k) - 1);
        end
        return m;
    endfunction

endpackage

/* src/dwpd_ram.sv */
// ----------------------------------------------------------------------------
// dwpd_ram - generic single-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dwpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dwpd_front.sv */
// ----------------------------------------------------------------------------
// dwpd_front - pixel intake and classification
// Qualifies each pixel, tracks raster position, keeps the line store and
// pushes one column item per pixel towards the window counter.
// ----------------------------------------------------------------------------
module dwpd_front import dwpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic               i_zone,
    input  logic               i_eof,
    input  t_fifo_status       i_fifo_status,
    output logic               o_push,
    output t_item              o_item
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             r_b_valid;
    logic             r_b_q;
    logic [COL_W-1:0] r_b_col;
    logic             r_b_judge;
    logic [LOC_W-1:0] r_b_locx;
    logic [LOC_W-1:0] r_b_locy;
    logic             r_b_eof;

    logic             accept;
    logic             qual;
    logic [JW-1:0]    ax;
    logic [JW-1:0]    ay;
    logic             judge;
    logic [LINES-1:0] rd_lines;
    logic [LINES-1:0] wr_lines;

    assign o_ready = !(i_fifo_status.full || (i_fifo_status.almost_full && r_b_valid));
    assign accept  = i_valid && o_ready;

    assign qual = i_zone && (i_depth > i_cfg.depth_th) &&
                  (MULT_W'(i_depth) * MULT_W'(SCALE_NUM) >
                   MULT_W'(i_cfg.pres_th) * MULT_W'(SCALE_DEN));

    assign ax = JW'(r_col) + JW'(1) - JW'(i_cfg.k);
    assign ay = JW'(r_row) + JW'(1) - JW'(i_cfg.k);

    assign judge = (JW'(r_col) + JW'(1) >= JW'(i_cfg.k)) &&
                   (JW'(r_row) + JW'(1) >= JW'(i_cfg.k)) &&
                   (ay >= JW'(i_cfg.row_first)) && (ay <= JW'(i_cfg.row_last));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_eof) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == COL_W'(IMAGE_WIDTH - 1)) begin
                n_col = '0;
                n_row = (r_row == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_b_valid <= accept;
        end
        if (accept) begin
            r_b_q     <= qual;
            r_b_col   <= r_col;
            r_b_judge <= judge;
            r_b_locx  <= LOC_W'(ax + JW'(LOC_OFFSET));
            r_b_locy  <= LOC_W'(ay + JW'(LOC_OFFSET));
            r_b_eof   <= i_eof;
        end
    end

    // shift the column history down one row and insert the new pixel
    assign wr_lines = LINES'({rd_lines, r_b_q});

    dwpd_ram #(
        .WIDTH (LINES),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata (wr_lines),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_lines)
    );

    assign o_push       = r_b_valid;
    assign o_item.vert  = {rd_lines, r_b_q};
    assign o_item.judge = r_b_judge;
    assign o_item.loc_x = r_b_locx;
    assign o_item.loc_y = r_b_locy;
    assign o_item.eof   = r_b_eof;

endmodule

/* src/dwpd_fifo.sv */
// ----------------------------------------------------------------------------
// dwpd_fifo - column item queue
// Short queue that lets the intake and the window counter stall apart.
// ----------------------------------------------------------------------------
module dwpd_fifo import dwpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_item        i_item,
    input  logic         i_pop,
    output logic         o_valid,
    output t_item        o_item,
    output t_fifo_status o_status
);

    t_item             r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr;
    logic [FPTR_W-1:0] r_rptr;
    logic [FCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    assign o_status.full        = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_status.almost_full = (r_count >= FCNT_W'(FIFO_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + FPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + FPTR_W'(1);
            end
            r_count <= r_count + FCNT_W'(i_push) - FCNT_W'(do_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* src/dwpd_back.sv */
// ----------------------------------------------------------------------------
// dwpd_back - window counter and frame summary
// Shifts columns into the window, counts qualified pixels, keeps the frame
// summary and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dwpd_back import dwpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [OUT_DATA_W-1:0] o_tdata
);

    logic [WIN_BITS-1:0] r_cwin;

    logic             r_j_valid;
    logic [PC_W-1:0]  r_j_pc [MAX_WINDOW];
    logic             r_j_anchor;
    logic             r_j_judge;
    logic [LOC_W-1:0] r_j_locx;
    logic [LOC_W-1:0] r_j_locy;
    logic             r_j_eof;

    logic             r_found, n_found;
    logic [LOC_W-1:0] r_fx, n_fx;
    logic [LOC_W-1:0] r_fy, n_fy;
    logic [CNT_W-1:0] r_best, n_best;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                out_busy;
    logic                j_go;
    logic                j_free;
    logic [WIN_BITS-1:0] win;
    logic [WIN_BITS-1:0] win_m;
    logic [PC_W-1:0]     pc [MAX_WINDOW];
    logic [CNT_W-1:0]    sum;
    logic                hit;

    assign out_busy = r_out_valid && !i_tready;
    assign j_go     = r_j_valid && !(r_j_eof && out_busy);
    assign j_free   = !r_j_valid || j_go;
    assign o_pop    = i_valid && j_free;

    assign win   = {r_cwin[WIN_BITS-MAX_WINDOW-1:0], i_item.vert};
    assign win_m = win & win_mask(i_cfg.k);

    always_comb begin
        for (int a = 0; a < MAX_WINDOW; a++) begin
            pc[a] = '0;
            for (int b = 0; b < MAX_WINDOW; b++) begin
                pc[a] = pc[a] + PC_W'(win_m[a * MAX_WINDOW + b]);
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int a = 0; a < MAX_WINDOW; a++) begin
            sum = sum + CNT_W'(r_j_pc[a]);
        end
        if (!r_j_anchor) begin
            sum = '0;
        end
    end

    assign hit = r_j_judge && r_j_anchor &&
                 (TW'(sum) + TW'(i_cfg.slack) >= TW'(i_cfg.k) * TW'(i_cfg.k));

    always_comb begin
        n_found = r_found;
        n_fx    = r_fx;
        n_fy    = r_fy;
        n_best  = r_best;
        if (hit) begin
            n_found = 1'b1;
            n_fx    = r_j_locx;
            n_fy    = r_j_locy;
        end
        if (r_j_judge && (sum > r_best)) begin
            n_best = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwin      <= '0;
            r_j_valid   <= 1'b0;
            r_found     <= 1'b0;
            r_fx        <= '0;
            r_fy        <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cwin <= i_item.eof ? '0 : win;
            end
            if (j_free) begin
                r_j_valid <= o_pop;
            end
            if (j_go) begin
                if (r_j_eof) begin
                    r_found <= 1'b0;
                    r_fx    <= '0;
                    r_fy    <= '0;
                    r_best  <= '0;
                end else begin
                    r_found <= n_found;
                    r_fx    <= n_fx;
                    r_fy    <= n_fy;
                    r_best  <= n_best;
                end
            end
            if (j_go && r_j_eof) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_j_pc     <= pc;
            r_j_anchor <= |(win & anchor_mask(i_cfg.k));
            r_j_judge  <= i_item.judge;
            r_j_locx   <= i_item.loc_x;
            r_j_locy   <= i_item.loc_y;
            r_j_eof    <= i_item.eof;
        end
        if (j_go && r_j_eof) begin
            r_out_data <= OUT_DATA_W'({MAXCNT_W'(n_best), n_fy, n_fx, n_found});
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule

/* src/depth_window_presence_detector.sv */
// ----------------------------------------------------------------------------
// depth_window_presence_detector - sliding window presence detector
// Counts qualified depth pixels in a square window and reports per frame.
// ----------------------------------------------------------------------------
// Takes one raster-order depth pixel per clock, with no gaps between rows or
// frames, unless an end of frame waits on an untaken summary and the queue
// fills; the pace is set by the line store, read and written once per pixel.
// The frame summary (detected flag, last detecting anchor plus two, largest
// window count) passes the intake register, queue, judge stage and output
// register, waiting there as later pixels flow; the line store gets no clearing
// pass after reset. Write the configuration only while no frame is in flight.
// ----------------------------------------------------------------------------
module depth_window_presence_detector import dwpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DEPTH_W-1:0]    s_axis_tdata,  // depth
    input  logic                  s_axis_tuser,  // in_zone
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // detected, loc_x, loc_y, max_count
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [DEPTH_W-1:0] r_depth_th;
    logic [DEPTH_W-1:0] r_pres_th;
    logic [WS_W-1:0]    r_win_size;
    logic [SLACK_W-1:0] r_slack;
    logic [BAND_W-1:0]  r_row_first;
    logic [BAND_W-1:0]  r_row_last;

    t_cfg         cfg;
    logic         push;
    t_item        push_item;
    logic         fifo_valid;
    t_item        fifo_item;
    t_fifo_status fifo_status;
    logic         pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_th  <= RST_DEPTH_TH;
            r_pres_th   <= RST_PRES_TH;
            r_win_size  <= RST_WS;
            r_slack     <= RST_SLACK;
            r_row_first <= RST_ROW_FIRST;
            r_row_last  <= RST_ROW_LAST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEPTH_TH:  r_depth_th  <= i_cfg_data[DEPTH_W-1:0];
                CFG_PRES_TH:   r_pres_th   <= i_cfg_data[DEPTH_W-1:0];
                CFG_WIN_SIZE:  r_win_size  <= i_cfg_data[WS_W-1:0];
                CFG_SLACK:     r_slack     <= i_cfg_data[SLACK_W-1:0];
                CFG_ROW_FIRST: r_row_first <= i_cfg_data[BAND_W-1:0];
                CFG_ROW_LAST:  r_row_last  <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.depth_th  = r_depth_th;
    assign cfg.pres_th   = r_pres_th;
    assign cfg.k         = clamp_k(r_win_size);
    assign cfg.slack     = r_slack;
    assign cfg.row_first = r_row_first;
    assign cfg.row_last  = r_row_last;

    dwpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_depth       (s_axis_tdata),
        .i_zone        (s_axis_tuser),
        .i_eof         (s_axis_tlast),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_item        (push_item)
    );

    dwpd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_valid  (fifo_valid),
        .o_item   (fifo_item),
        .o_status (fifo_status)
    );

    dwpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (fifo_valid),
        .i_item   (fifo_item),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_status.full)
        else $error("column item pushed into a full queue");

    a_no_loc_without_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[2*LOC_W:1] == '0))
        else $error("location reported without a detection");

    a_window_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg.k != '0) && (int'(cfg.k) <= MAX_WINDOW))
        else $error("window side out of range");

endmodule
